[sv/qcsr_pkg.sv]
// Shared types, constants and helper functions for the quadrature counter
// and SPI readout core. No dependencies.
`default_nettype none

package qcsr_pkg;

    // Frame and channel geometry
    localparam int FRAME_BYTES       = 8;
    localparam int PAIR_SLOTS        = FRAME_BYTES / 2;
    localparam int ENCODER_COUNT     = 3;
    localparam int PRESSURE_CHANNELS = 3;
    localparam int PRESSURE_FIELDS   = 3;
    localparam int PIN_W             = 6;
    localparam int PIN_CHANNELS      = PIN_W / 2;
    localparam int CMD_W             = 8;
    localparam int SAMPLE_W          = 12;
    localparam int COUNT_W           = 32;
    localparam int WORD_W            = 16;

    // Packed beat widths: pins, command, three samples, padded to bytes
    localparam int IN_FIELDS_W = PIN_W + CMD_W + PRESSURE_FIELDS * SAMPLE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = FRAME_BYTES * 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ENCODER  = 8'hFD;
    localparam logic [CMD_W-1:0] CMD_PRESSURE = 8'hFC;
    localparam logic [CMD_W-1:0] CMD_CHECK    = 8'hFB;
    localparam logic [7:0]       CHECK_FILL   = 8'hFC;

    typedef enum logic [1:0] {
        MODE_CONFIG   = 2'd0,
        MODE_ENCODER  = 2'd1,
        MODE_PRESSURE = 2'd2,
        MODE_CHECK    = 2'd3
    } t_reply_mode;

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [7:0]          t_byte;

    // Frame request handed from the input stage to the reply buffer
    typedef struct packed {
        logic                   fire;
        logic [CMD_W-1:0]       cmd;
        t_sample [PAIR_SLOTS-1:0] pressure;
    } t_frame_req;

    // Buffer contents after reset
    localparam t_byte [FRAME_BYTES-1:0] BUFFER_RESET = {
        8'h3b, 8'h3a, 8'h2b, 8'h2a, 8'h1b, 8'h1a, 8'h0b, 8'h0a
    };

    // Quadrature transition table: -1, 0 or +1 from {old AB, new AB}
    function automatic logic signed [1:0] step_lookup(input logic [3:0] hist);
        logic signed [1:0] s;
        case (hist)
            4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
            default: s = 2'sd0;
        endcase
        return s;
    endfunction

    function automatic t_reply_mode decode_cmd(input logic [CMD_W-1:0] cmd);
        t_reply_mode m;
        case (cmd)
            CMD_ENCODER:  m = MODE_ENCODER;
            CMD_PRESSURE: m = MODE_PRESSURE;
            CMD_CHECK:    m = MODE_CHECK;
            default:      m = MODE_CONFIG;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

[sv/quadrature_counter_spi_readout_core.sv]
// Top level: input beat register feeding the encoder counters and the reply
// buffer. Depends on qcsr_pkg, qcsr_counter and qcsr_reply.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: mode, tdata: pins, cmd, samples
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: reply bytes 0..7
//
// One beat per cycle is accepted while the input is not stalled. A frame beat
// passes through the input register, then the buffer/output register, before it
// shows on m_axis; a tick beat passes through the input register and then
// updates the counters, and makes no output.
// Reset (i_rst_n low, synchronous) clears counts and history, loads the buffer
// pattern and empties both registers. A stalled output holds the buffer; input
// stalls only while a frame waits behind an output beat not yet taken.
`default_nettype none

module quadrature_counter_spi_readout_core #(
    parameter int ENCODER_COUNT = qcsr_pkg::ENCODER_COUNT
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: encoder_pins[5:0], command_byte[13:6], pressure_0[25:14],
    //        pressure_1[37:26], pressure_2[49:38], zero pad
    input  wire logic [qcsr_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // tuser: mode (0 tick, 1 frame)
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: reply_byte_0 .. reply_byte_7, 8 bits each
    output logic [qcsr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int SampleBase = qcsr_pkg::PIN_W + qcsr_pkg::CMD_W;

    logic                                  r_in_valid;
    logic                                  r_in_mode;
    logic [qcsr_pkg::IN_TDATA_W-1:0]       r_in_data;
    logic                                  w_advance;
    logic                                  w_accept;
    qcsr_pkg::t_frame_req                  w_req;
    qcsr_pkg::t_word [qcsr_pkg::PAIR_SLOTS-1:0] w_enc_word;
    qcsr_pkg::t_byte [qcsr_pkg::FRAME_BYTES-1:0] w_buffer;

    // a tick always leaves; a frame leaves when the output register is free
    assign w_advance     = r_in_valid && (!r_in_mode || !m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_mode <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
    end

    // frame request; sample slots without an input field send zero
    always_comb begin
        w_req.fire = w_advance && r_in_mode;
        w_req.cmd  = r_in_data[qcsr_pkg::PIN_W +: qcsr_pkg::CMD_W];
        for (int i = 0; i < qcsr_pkg::PAIR_SLOTS; i++) begin
            if (i < qcsr_pkg::PRESSURE_FIELDS) begin
                w_req.pressure[i] = r_in_data[SampleBase + i*qcsr_pkg::SAMPLE_W +:
                                              qcsr_pkg::SAMPLE_W];
            end else begin
                w_req.pressure[i] = '0;
            end
        end
    end

    qcsr_counter #(
        .EncoderCount (ENCODER_COUNT)
    ) u_counter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_advance && !r_in_mode),
        .i_pins     (r_in_data[qcsr_pkg::PIN_W-1:0]),
        .o_enc_word (w_enc_word)
    );

    qcsr_reply #(
        .EncoderCount (ENCODER_COUNT)
    ) u_reply (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_enc_word  (w_enc_word),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_buffer    (w_buffer)
    );

    assign m_axis_tdata = w_buffer;

endmodule

`default_nettype wire

[sv/qcsr_counter.sv]
// Per-encoder phase history and signed position counters.
// Depends on qcsr_pkg.
`default_nettype none

module qcsr_counter #(
    parameter int EncoderCount = qcsr_pkg::ENCODER_COUNT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_tick,
    input  wire logic [qcsr_pkg::PIN_W-1:0]   i_pins,
    output qcsr_pkg::t_word [qcsr_pkg::PAIR_SLOTS-1:0] o_enc_word
);

    genvar g;
    generate
        for (g = 0; g < qcsr_pkg::PAIR_SLOTS; g++) begin : g_chan
            if (g < EncoderCount) begin : g_live
                logic [1:0]                      w_pair;
                logic [3:0]                      r_hist, n_hist;
                logic [qcsr_pkg::COUNT_W-1:0]    r_count, n_count;
                logic signed [1:0]               w_step;

                // channels past the pin field read as zero
                if (g < qcsr_pkg::PIN_CHANNELS) begin : g_pins
                    assign w_pair = i_pins[2*g+1 -: 2];
                end else begin : g_nopins
                    assign w_pair = 2'b00;
                end

                always_comb begin
                    n_hist  = {r_hist[1:0], w_pair};
                    w_step  = qcsr_pkg::step_lookup(n_hist);
                    n_count = r_count + {{(qcsr_pkg::COUNT_W-2){w_step[1]}}, w_step};
                end

                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_hist  <= '0;
                        r_count <= '0;
                    end else if (i_tick) begin
                        r_hist  <= n_hist;
                        r_count <= n_count;
                    end
                end

                // negative counts report as zero
                assign o_enc_word[g] = r_count[qcsr_pkg::COUNT_W-1] ? '0
                                     : r_count[qcsr_pkg::WORD_W-1:0];
            end else begin : g_idle
                assign o_enc_word[g] = '0;
            end
        end
    endgenerate

endmodule

`default_nettype wire

[sv/qcsr_reply.sv]
// Transmit buffer update and output beat register for the SPI readout.
// Depends on qcsr_pkg.
`default_nettype none

module qcsr_reply #(
    parameter int EncoderCount = qcsr_pkg::ENCODER_COUNT
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire qcsr_pkg::t_frame_req                  i_req,
    input  wire qcsr_pkg::t_word [qcsr_pkg::PAIR_SLOTS-1:0] i_enc_word,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output qcsr_pkg::t_byte [qcsr_pkg::FRAME_BYTES-1:0] o_buffer
);

    qcsr_pkg::t_byte [qcsr_pkg::FRAME_BYTES-1:0] r_buf, n_buf;
    logic                                       r_valid, n_valid;
    qcsr_pkg::t_reply_mode                      w_mode;
    qcsr_pkg::t_word                            w_word;

    // next buffer contents for the decoded mode
    always_comb begin
        w_mode = qcsr_pkg::decode_cmd(i_req.cmd);
        n_buf  = r_buf;
        w_word = '0;
        case (w_mode)
            qcsr_pkg::MODE_ENCODER: begin
                for (int i = 0; i < qcsr_pkg::PAIR_SLOTS; i++) begin
                    if (i < EncoderCount) begin
                        n_buf[2*i]   = i_enc_word[i][15:8];
                        n_buf[2*i+1] = i_enc_word[i][7:0];
                    end
                end
            end
            qcsr_pkg::MODE_PRESSURE: begin
                for (int i = 0; i < qcsr_pkg::PAIR_SLOTS; i++) begin
                    if (i < qcsr_pkg::PRESSURE_CHANNELS) begin
                        w_word       = {4'd0, i_req.pressure[i]};
                        n_buf[2*i]   = w_word[15:8];
                        n_buf[2*i+1] = w_word[7:0];
                    end
                end
            end
            qcsr_pkg::MODE_CHECK: begin
                for (int i = 1; i <= 6; i++) begin
                    n_buf[i] = qcsr_pkg::CHECK_FILL;
                end
            end
            default: begin
                n_buf = r_buf;
            end
        endcase
    end

    // output beat valid: set on a frame, cleared when taken
    always_comb begin
        n_valid = r_valid;
        if (i_req.fire) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= qcsr_pkg::BUFFER_RESET;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_req.fire) begin
                r_buf <= n_buf;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_buffer    = r_buf;

endmodule

`default_nettype wire

[sv/qcsr_checker.sv]
// Port-level checks for quadrature_counter_spi_readout_core, bound to the top.
// Depends on qcsr_pkg.
`default_nettype none

module qcsr_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [qcsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid after reset");

    // with no beat waiting on the output, input is never stalled
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

    // a ready consumer never backs up the input
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    // a stalled reply beat holds its bytes
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled reply beat changed");

endmodule

bind quadrature_counter_spi_readout_core qcsr_checker u_qcsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking bench for quadrature_counter_spi_readout_core: drives tick and
// frame beats, predicts every reply frame and compares it byte by byte.
// Depends on qcsr_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET = 1850;
    localparam int QUIET_LIMIT = 2000;

    typedef logic [qcsr_pkg::PIN_W-1:0] t_pins;
    typedef logic [qcsr_pkg::CMD_W-1:0] t_cmd;

    // One input beat as the bench sees it
    typedef struct packed {
        logic                    frame;
        t_pins                   pins;
        t_cmd                    cmd;
        qcsr_pkg::t_sample [2:0] press;
    } t_beat_item;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // tdata: encoder_pins, command_byte, pressure_0, pressure_1, pressure_2, zero pad
    logic [qcsr_pkg::IN_TDATA_W-1:0]    s_axis_tdata = '0;
    // tuser: mode (0 tick, 1 frame)
    logic                               s_axis_tuser = 1'b0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // tdata: reply_byte_0 .. reply_byte_7
    logic [qcsr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;

    quadrature_counter_spi_readout_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted block state
    logic [3:0]                   phase_hist [qcsr_pkg::ENCODER_COUNT];
    logic [qcsr_pkg::COUNT_W-1:0] pos_count  [qcsr_pkg::ENCODER_COUNT];
    qcsr_pkg::t_byte              tx_buf     [qcsr_pkg::FRAME_BYTES];
    int step_by_hist [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

    // Gray-code successor of a pin pair, counting up and counting down
    int up_next   [4] = '{2, 0, 3, 1};
    int down_next [4] = '{1, 3, 0, 2};

    t_beat_item                         beat_queue [$];
    logic [qcsr_pkg::OUT_TDATA_W-1:0]   reply_due  [$];
    t_beat_item                         beat_now = '0;
    logic                               s_taken = 1'b0;
    int                                 feed_gap = 0;
    int                                 stall_left = 0;
    logic                               s_steady = 1'b0;
    logic                               m_steady = 1'b0;
    int                                 quiet_cycles = 0;
    int                                 mismatch_count = 0;
    int                                 item_total = 0;
    int                                 cur_pair [qcsr_pkg::ENCODER_COUNT];
    int                                 drift [qcsr_pkg::ENCODER_COUNT];

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Tick: shift each channel's pin pair into its history and step the count
    function automatic void advance_encoders(input t_pins pins);
        logic [1:0] pair;
        for (int ch = 0; ch < qcsr_pkg::ENCODER_COUNT; ch++) begin
            pair = (2 * ch < qcsr_pkg::PIN_W) ? pins[2*ch +: 2] : 2'b00;
            phase_hist[ch] = {phase_hist[ch][1:0], pair};
            pos_count[ch] = pos_count[ch] + step_by_hist[phase_hist[ch]];
        end
    endfunction

    // Frame: update the transmit buffer for the command and return it packed
    function automatic logic [qcsr_pkg::OUT_TDATA_W-1:0] frame_reply(
            input t_cmd cmd, input qcsr_pkg::t_sample [2:0] press);
        qcsr_pkg::t_reply_mode            mode;
        qcsr_pkg::t_word                  word;
        logic [qcsr_pkg::OUT_TDATA_W-1:0] packed_buf;
        case (cmd)
            qcsr_pkg::CMD_ENCODER:  mode = qcsr_pkg::MODE_ENCODER;
            qcsr_pkg::CMD_PRESSURE: mode = qcsr_pkg::MODE_PRESSURE;
            qcsr_pkg::CMD_CHECK:    mode = qcsr_pkg::MODE_CHECK;
            default:                mode = qcsr_pkg::MODE_CONFIG;
        endcase
        case (mode)
            qcsr_pkg::MODE_ENCODER: begin
                // negative counts go out as zero
                for (int ch = 0; ch < qcsr_pkg::ENCODER_COUNT; ch++) begin
                    word = pos_count[ch][qcsr_pkg::COUNT_W-1] ? '0
                         : pos_count[ch][qcsr_pkg::WORD_W-1:0];
                    if (2 * ch + 1 < qcsr_pkg::FRAME_BYTES) begin
                        tx_buf[2*ch]     = word[15:8];
                        tx_buf[2*ch + 1] = word[7:0];
                    end
                end
            end
            qcsr_pkg::MODE_PRESSURE: begin
                for (int ch = 0; ch < qcsr_pkg::PRESSURE_CHANNELS; ch++) begin
                    word = (ch < qcsr_pkg::PRESSURE_FIELDS) ? qcsr_pkg::t_word'(press[ch])
                                                            : '0;
                    if (2 * ch + 1 < qcsr_pkg::FRAME_BYTES) begin
                        tx_buf[2*ch]     = word[15:8];
                        tx_buf[2*ch + 1] = word[7:0];
                    end
                end
            end
            qcsr_pkg::MODE_CHECK: begin
                for (int i = 1; i <= 6; i++)
                    tx_buf[i] = qcsr_pkg::CHECK_FILL;
            end
            default: begin
                // config mode leaves the buffer alone
            end
        endcase
        for (int i = 0; i < qcsr_pkg::FRAME_BYTES; i++)
            packed_buf[8*i +: 8] = tx_buf[i];
        return packed_buf;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_tick(input t_pins pins, input t_cmd cmd,
                             input qcsr_pkg::t_sample [2:0] press);
        t_beat_item item;
        item.frame = 1'b0;
        item.pins  = pins;
        item.cmd   = cmd;
        item.press = press;
        beat_queue.push_back(item);
        for (int ch = 0; ch < qcsr_pkg::ENCODER_COUNT; ch++)
            cur_pair[ch] = pins[2*ch +: 2];
        item_total++;
    endtask

    // Move each channel one quadrature step: +1 up, -1 down, 0 hold
    task automatic push_step(input int d0, input int d1, input int d2);
        t_pins pins;
        int    dir [qcsr_pkg::ENCODER_COUNT];
        dir[0] = d0;
        dir[1] = d1;
        dir[2] = d2;
        for (int ch = 0; ch < qcsr_pkg::ENCODER_COUNT; ch++) begin
            if (dir[ch] > 0)
                pins[2*ch +: 2] = 2'(up_next[cur_pair[ch]]);
            else if (dir[ch] < 0)
                pins[2*ch +: 2] = 2'(down_next[cur_pair[ch]]);
            else
                pins[2*ch +: 2] = 2'(cur_pair[ch]);
        end
        push_tick(pins, t_cmd'($urandom_range(0, 255)),
                  {12'($urandom), 12'($urandom), 12'($urandom)});
    endtask

    task automatic push_frame(input t_cmd cmd, input qcsr_pkg::t_sample [2:0] press);
        t_beat_item item;
        item.frame = 1'b1;
        item.pins  = t_pins'($urandom);
        item.cmd   = cmd;
        item.press = press;
        beat_queue.push_back(item);
        item_total++;
    endtask

    // Input driver: beats change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_taken) begin
            if (feed_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                feed_gap <= feed_gap - 1;
            end else if (beat_queue.size() > 0) begin
                beat_now = beat_queue.pop_front();
                s_axis_tdata <= {{(qcsr_pkg::IN_TDATA_W - qcsr_pkg::IN_FIELDS_W){1'b0}},
                                 beat_now.press[2], beat_now.press[1], beat_now.press[0],
                                 beat_now.cmd, beat_now.pins};
                s_axis_tuser <= beat_now.frame;
                s_axis_tvalid <= 1'b1;
                feed_gap <= s_steady ? 0 : pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        if ($urandom_range(0, 199) == 0)
            s_steady <= !s_steady;
    end

    // Output back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (m_steady || stall_left == 0) begin
            m_axis_tready <= 1'b1;
            if (!m_steady && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end else begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        if ($urandom_range(0, 199) == 0)
            m_steady <= !m_steady;
    end

    // Monitor: predict on accepted input beats, check accepted reply beats
    always @(posedge i_clk) begin
        logic [qcsr_pkg::OUT_TDATA_W-1:0] want;
        if (!i_rst_n) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                if (beat_now.frame)
                    reply_due.push_back(frame_reply(beat_now.cmd, beat_now.press));
                else
                    advance_encoders(beat_now.pins);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (reply_due.size() == 0) begin
                    report_mismatch($sformatf("reply beat %h with none expected",
                                              m_axis_tdata));
                end else begin
                    want = reply_due.pop_front();
                    for (int i = 0; i < qcsr_pkg::FRAME_BYTES; i++)
                        if (m_axis_tdata[8*i +: 8] !== want[8*i +: 8])
                            report_mismatch($sformatf("reply_byte_%0d got %h want %h",
                                                      i, m_axis_tdata[8*i +: 8],
                                                      want[8*i +: 8]));
                end
            end
            // watchdog on cycles where neither side moves a beat
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int r;
        int dir [qcsr_pkg::ENCODER_COUNT];
        for (int ch = 0; ch < qcsr_pkg::ENCODER_COUNT; ch++) begin
            phase_hist[ch] = '0;
            pos_count[ch]  = '0;
            cur_pair[ch]   = 0;
            drift[ch]      = ($urandom_range(0, 1) == 0) ? 1 : -1;
        end
        for (int i = 0; i < qcsr_pkg::FRAME_BYTES; i++)
            tx_buf[i] = qcsr_pkg::BUFFER_RESET[i];

        // Directed: reset pattern, each command, pressure extremes
        push_frame(8'h00, {12'h123, 12'h456, 12'h789});
        push_frame(qcsr_pkg::CMD_ENCODER, {12'hABC, 12'hDEF, 12'h012});
        push_frame(qcsr_pkg::CMD_CHECK, '0);
        push_frame(qcsr_pkg::CMD_PRESSURE, {12'h000, 12'h000, 12'h000});
        push_frame(qcsr_pkg::CMD_PRESSURE, {12'hFFF, 12'hFFF, 12'hFFF});
        push_frame(8'hFF, {12'h555, 12'hAAA, 12'h5A5});
        push_frame(8'hFE, '0);
        push_frame(8'hFA, '0);
        // ticks ignore command and samples; a double jump counts nothing
        push_tick(6'h3F, qcsr_pkg::CMD_PRESSURE, {12'hFFF, 12'hFFF, 12'hFFF});
        push_tick(6'h00, qcsr_pkg::CMD_ENCODER, {12'h800, 12'h800, 12'h800});
        // channel 0 up, channel 1 down to a negative count, channel 2 up
        push_step(1, -1, 1);
        push_step(1, -1, 1);
        push_step(1, -1, 0);
        push_step(1, -1, 1);
        push_frame(qcsr_pkg::CMD_ENCODER, '0);
        push_frame(qcsr_pkg::CMD_CHECK, {12'hFFF, 12'h000, 12'hFFF});
        push_step(-1, 1, -1);
        push_step(0, 1, -1);
        push_step(-1, 1, -1);
        push_frame(qcsr_pkg::CMD_ENCODER, '0);
        push_frame(qcsr_pkg::CMD_PRESSURE, {12'h001, 12'h800, 12'h7FF});

        // Random: mostly clean quadrature motion, some noise, frames mixed in
        while (item_total < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                for (int ch = 0; ch < qcsr_pkg::ENCODER_COUNT; ch++) begin
                    if ($urandom_range(0, 119) == 0)
                        drift[ch] = -drift[ch];
                    case ($urandom_range(0, 19))
                        0, 1, 2:  dir[ch] = 0;
                        3, 4, 5:  dir[ch] = -drift[ch];
                        default:  dir[ch] = drift[ch];
                    endcase
                end
                push_step(dir[0], dir[1], dir[2]);
            end else if (r < 64) begin
                push_tick(t_pins'($urandom), t_cmd'($urandom), '0);
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5: push_frame(qcsr_pkg::CMD_ENCODER, '0);
                    6, 7, 8, 9, 10:
                        push_frame(qcsr_pkg::CMD_PRESSURE,
                                   {12'($urandom), 12'($urandom), 12'($urandom)});
                    11: push_frame(qcsr_pkg::CMD_PRESSURE,
                                   {12'hFFF, 12'h000, 12'($urandom)});
                    12, 13, 14: push_frame(qcsr_pkg::CMD_CHECK, '0);
                    default: push_frame(t_cmd'($urandom_range(0, 255)),
                                        {12'($urandom), 12'($urandom), 12'($urandom)});
                endcase
            end
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beat_queue.size() != 0 || s_axis_tvalid || reply_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[sim.f]
sv/qcsr_pkg.sv
sv/qcsr_counter.sv
sv/qcsr_reply.sv
sv/quadrature_counter_spi_readout_core.sv
sv/qcsr_checker.sv
tb/sv/tb.sv
